// File: rtl/dqne_pkg.sv
// dqne_pkg: shared types and constants for the dns query name extractor
// used by every module of the block and by its checker

package dqne_pkg;

    localparam int BYTE_W     = 8;
    localparam int NAME_LEN_W = 9;
    localparam int PORT_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DNS_PORT     = 1'd1;

    // reset values of the configuration registers
    localparam logic [NAME_LEN_W-1:0] MAX_NAME_LEN_RESET = 9'd256;
    localparam logic [PORT_W-1:0]     DNS_PORT_RESET     = 16'd53;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_IPV4  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_UDP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG_PORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_QUERY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd5;

    localparam logic [15:0]       ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [BYTE_W-1:0] IP_PROTO_UDP   = 8'd17;
    localparam logic [BYTE_W-1:0] ASCII_DOT      = 8'h2e;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   name_char;
        logic                char_valid;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_t;

    typedef struct packed {
        logic [NAME_LEN_W-1:0] max_name_len;
        logic [PORT_W-1:0]     dns_port;
    } cfg_t;

endpackage

// File: rtl/dqne_parser.sv
// dqne_parser: per-byte frame parser state and the step logic that forms one result
// depends on dqne_pkg

module dqne_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  dqne_pkg::in_t  in_data,
    input  dqne_pkg::cfg_t cfg,
    output dqne_pkg::out_t result,
    output logic          has_result
);
    import dqne_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LEN    = 2'd1;
    localparam logic [1:0] PH_LABEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [6:0] OFF_MAX     = 7'd127;
    localparam logic [6:0] OFF_TYPE_HI = 7'd12;
    localparam logic [6:0] OFF_TYPE_LO = 7'd13;
    localparam logic [6:0] OFF_IHL     = 7'd14;
    localparam logic [6:0] OFF_PROTO   = 7'd23;
    localparam logic [3:0] IHL_MIN     = 4'd5;

    logic [6:0]            offset_reg,   offset_next;
    logic [1:0]            phase_reg,    phase_next;
    logic [3:0]            hwords_reg,   hwords_next;
    logic [BYTE_W-1:0]     held_reg,     held_next;
    logic [BYTE_W-1:0]     label_reg,    label_next;
    logic [NAME_LEN_W-1:0] emitted_reg,  emitted_next;

    logic [BYTE_W-1:0]     b;
    logic [6:0]            udp_off;
    logic [NAME_LEN_W-1:0] limit;
    logic                  fin;

    assign b       = in_data.frame_byte;
    assign udp_off = OFF_IHL + {1'b0, hwords_reg, 2'b00};
    assign limit   = (cfg.max_name_len == '0) ? '0 : cfg.max_name_len - 1'b1;

    always_comb begin
        offset_next  = offset_reg;
        phase_next   = phase_reg;
        hwords_next  = hwords_reg;
        held_next    = held_reg;
        label_next   = label_reg;
        emitted_next = emitted_reg;
        result       = '0;
        result.status = ST_OK;
        fin          = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                if (offset_reg == OFF_TYPE_HI) begin
                    held_next = b;
                end else if (offset_reg == OFF_TYPE_LO) begin
                    if ({held_reg, b} != ETHERTYPE_IPV4) begin
                        result.status = ST_NOT_IPV4;
                        fin = 1'b1;
                    end
                end else if (offset_reg == OFF_IHL) begin
                    hwords_next = (b[3:0] < IHL_MIN) ? IHL_MIN : b[3:0];
                end else if (offset_reg == OFF_PROTO) begin
                    if (b != IP_PROTO_UDP) begin
                        result.status = ST_NOT_UDP;
                        fin = 1'b1;
                    end
                end else if (offset_reg == udp_off + 7'd2) begin
                    held_next = b;
                end else if (offset_reg == udp_off + 7'd3) begin
                    if ({held_reg, b} != cfg.dns_port) begin
                        result.status = ST_WRONG_PORT;
                        fin = 1'b1;
                    end
                end else if (offset_reg == udp_off + 7'd10) begin
                    // qr flag set means a response
                    if (b[7]) begin
                        result.status = ST_NOT_QUERY;
                        fin = 1'b1;
                    end
                end else if (offset_reg == udp_off + 7'd20) begin
                    // first length byte of the question name
                    if (b == '0 || limit == '0) begin
                        fin = 1'b1;
                    end else begin
                        label_next = b;
                        phase_next = PH_LABEL;
                    end
                end
            end
            PH_LABEL: begin
                result.name_char  = b;
                result.char_valid = 1'b1;
                emitted_next = emitted_reg + 1'b1;
                label_next   = label_reg - 1'b1;
                if (emitted_next >= limit) begin
                    fin = 1'b1;
                end else if (label_next == '0) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b == '0) begin
                    fin = 1'b1;
                end else begin
                    result.name_char  = ASCII_DOT;
                    result.char_valid = 1'b1;
                    emitted_next = emitted_reg + 1'b1;
                    label_next   = b;
                    if (emitted_next >= limit) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_LABEL;
                    end
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            result.last = 1'b1;
            phase_next  = PH_DONE;
        end

        if (in_data.frame_end) begin
            // frame ran out before the name finished
            if (!fin && phase_next != PH_DONE) begin
                result.status = ST_SHORT;
                result.last   = 1'b1;
                fin           = 1'b1;
            end
            offset_next  = '0;
            phase_next   = PH_HEADER;
            hwords_next  = IHL_MIN;
            held_next    = '0;
            label_next   = '0;
            emitted_next = '0;
        end else if (offset_reg < OFF_MAX) begin
            offset_next = offset_reg + 1'b1;
        end

        has_result = fin || result.char_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            phase_reg   <= PH_HEADER;
            hwords_reg  <= IHL_MIN;
            held_reg    <= '0;
            label_reg   <= '0;
            emitted_reg <= '0;
        end else if (step_en) begin
            offset_reg  <= offset_next;
            phase_reg   <= phase_next;
            hwords_reg  <= hwords_next;
            held_reg    <= held_next;
            label_reg   <= label_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// File: rtl/dns_query_name_extractor.sv
// dns_query_name_extractor: top level with input register, parser and result register
// depends on dqne_pkg and dqne_parser
//
//   channel  | direction | ports                    | carries
//   ---------+-----------+--------------------------+-----------------------------------
//   s_       | in        | s_valid s_ready s_data   | one frame byte and end-of-frame flag
//   m_       | out       | m_valid m_ready m_data   | name char and/or final status
//   cfg_     | in        | cfg_we cfg_index cfg_wdata | max_name_len, dns_port writes
//
// one byte per cycle sustained while m_ready keeps the result register free; a byte is held
// in the input register, then the parser step loads the result register
// a byte leaves the input register only when the result register is free or drained
// s_ready stays high while the input register is empty, even with a result waiting
// reset clears both valid flags and the parser, config returns to 256 and port 53

module dns_query_name_extractor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dqne_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dqne_pkg::out_t                      m_data,
    input  logic                                cfg_we,
    input  logic [dqne_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dqne_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dqne_pkg::*;

    logic  in_valid_reg;
    in_t   in_data_reg;
    logic  m_valid_reg;
    out_t  m_data_reg;
    cfg_t  cfg_reg;

    logic  out_free;
    logic  step;
    out_t  result;
    logic  has_result;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && has_result) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_name_len <= MAX_NAME_LEN_RESET;
            cfg_reg.dns_port     <= DNS_PORT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_NAME_LEN: cfg_reg.max_name_len <= cfg_wdata[NAME_LEN_W-1:0];
                CFG_DNS_PORT:     cfg_reg.dns_port     <= cfg_wdata[PORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dqne_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step),
        .in_data    (in_data_reg),
        .cfg        (cfg_reg),
        .result     (result),
        .has_result (has_result)
    );

endmodule

// File: rtl/dqne_checker.sv
// dqne_checker: port-level assertions for dns_query_name_extractor, bound to the top level
// depends on dqne_pkg

module dqne_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input dqne_pkg::in_t                   s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input dqne_pkg::out_t                  m_data
);
    import dqne_pkg::*;

    // a waiting byte holds until its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input byte changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only the final transfer of a frame may lack a character
    a_mid_has_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.char_valid && m_data.status == ST_OK)
        else $error("non-final transfer without character or with status");

    // no character without char_valid
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.char_valid |-> m_data.name_char == '0)
        else $error("name_char set without char_valid");

    // a reject never comes with a character
    a_reject_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid |-> m_data.status == ST_OK || m_data.status == ST_SHORT)
        else $error("reject status carried a character");

endmodule

bind dns_query_name_extractor dqne_checker u_dqne_checker (.*);

// File: tb/dns_query_name_extractor_chk.sv
`timescale 1ns / 1ps
// dns_query_name_extractor_chk: watches the byte and name channels of the extractor,
// predicts each name result from the accepted frame bytes and compares in order
// depends on dqne_pkg

module dns_query_name_extractor_chk
    import dqne_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    error_count,
    output int                    results_due
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LEN,
        PH_LABEL,
        PH_DONE
    } parse_phase_t;

    logic [NAME_LEN_W-1:0] name_len_cfg = MAX_NAME_LEN_RESET;
    logic [PORT_W-1:0]     port_cfg     = DNS_PORT_RESET;

    logic [6:0]            byte_offset;
    parse_phase_t          phase;
    logic [3:0]            header_words;
    logic [7:0]            held_high_byte;
    logic [7:0]            label_remaining;
    logic [NAME_LEN_W-1:0] chars_emitted;

    out_t name_results_due[$];
    out_t predicted;
    out_t oldest;

    initial begin
        error_count = 0;
        results_due = 0;
    end

    function automatic void clear_parser();
        byte_offset     = '0;
        phase           = PH_HEADER;
        header_words    = 4'd5;
        held_high_byte  = '0;
        label_remaining = '0;
        chars_emitted   = '0;
    endfunction

    // advances the parser copy by one frame byte; returns 1 when a name result is due
    function automatic bit step_name_parser(input in_t item, output out_t res);
        logic [7:0]            b;
        logic [NAME_LEN_W-1:0] limit;
        int                    off;
        int                    udp;
        bit                    finished;
        b        = item.frame_byte;
        off      = int'(byte_offset);
        limit    = (name_len_cfg != '0) ? name_len_cfg - 1'b1 : '0;
        res      = '0;
        finished = 1'b0;
        case (phase)
            PH_HEADER: begin
                udp = 14 + 4 * int'(header_words);
                if (off == 12) begin
                    held_high_byte = b;
                end else if (off == 13) begin
                    if ({held_high_byte, b} != ETHERTYPE_IPV4) begin
                        res.status = ST_NOT_IPV4;
                        finished   = 1'b1;
                    end
                end else if (off == 14) begin
                    // ihl below five counts as five
                    header_words = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
                end else if (off == 23) begin
                    if (b != IP_PROTO_UDP) begin
                        res.status = ST_NOT_UDP;
                        finished   = 1'b1;
                    end
                end else if (off == udp + 2) begin
                    held_high_byte = b;
                end else if (off == udp + 3) begin
                    if ({held_high_byte, b} != port_cfg) begin
                        res.status = ST_WRONG_PORT;
                        finished   = 1'b1;
                    end
                end else if (off == udp + 10) begin
                    if (b[7]) begin
                        res.status = ST_NOT_QUERY;
                        finished   = 1'b1;
                    end
                end else if (off == udp + 20) begin
                    // first length byte of the question name
                    if (b == 8'd0 || limit == '0) begin
                        finished = 1'b1;
                    end else begin
                        label_remaining = b;
                        phase           = PH_LABEL;
                    end
                end
            end
            PH_LABEL: begin
                res.name_char  = b;
                res.char_valid = 1'b1;
                chars_emitted++;
                label_remaining--;
                if (chars_emitted >= limit) begin
                    finished = 1'b1;
                end else if (label_remaining == 8'd0) begin
                    phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b == 8'd0) begin
                    finished = 1'b1;
                end else begin
                    res.name_char   = ASCII_DOT;
                    res.char_valid  = 1'b1;
                    chars_emitted++;
                    label_remaining = b;
                    if (chars_emitted >= limit) begin
                        finished = 1'b1;
                    end else begin
                        phase = PH_LABEL;
                    end
                end
            end
            default: ;
        endcase
        if (finished) begin
            res.last = 1'b1;
            phase    = PH_DONE;
        end
        if (item.frame_end) begin
            // frame cut before the name was done
            if (phase != PH_DONE) begin
                res.status = ST_SHORT;
                res.last   = 1'b1;
                finished   = 1'b1;
            end
            clear_parser();
        end else if (byte_offset < 7'd127) begin
            byte_offset++;
        end
        return finished || res.char_valid;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            name_len_cfg = MAX_NAME_LEN_RESET;
            port_cfg     = DNS_PORT_RESET;
            clear_parser();
            name_results_due.delete();
        end else begin
            // result side first: a result never belongs to a byte of the same edge
            if (m_valid && m_ready) begin
                if (name_results_due.size() == 0) begin
                    $display("%0t: unexpected result: char %h valid %b status %0d last %b",
                             $time, m_data.name_char, m_data.char_valid, m_data.status,
                             m_data.last);
                    error_count++;
                end else begin
                    oldest = name_results_due.pop_front();
                    if (m_data.name_char !== oldest.name_char ||
                        m_data.char_valid !== oldest.char_valid ||
                        m_data.status !== oldest.status ||
                        m_data.last !== oldest.last) begin
                        $display("%0t: expected char %h vld %b st %0d last %b, got %h %b %0d %b",
                                 $time, oldest.name_char, oldest.char_valid, oldest.status,
                                 oldest.last, m_data.name_char, m_data.char_valid,
                                 m_data.status, m_data.last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (step_name_parser(s_data, predicted)) begin
                    name_results_due.push_back(predicted);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_NAME_LEN: name_len_cfg = cfg_wdata[NAME_LEN_W-1:0];
                    CFG_DNS_PORT:     port_cfg     = cfg_wdata[PORT_W-1:0];
                    default: ;
                endcase
            end
        end
        results_due = name_results_due.size();
    end

endmodule

// File: tb/dns_query_name_extractor_tb.sv
`timescale 1ns / 1ps
// dns_query_name_extractor_tb: builds ethernet frames byte by byte, programs the
// name length and port registers between phases and gives the verdict
// depends on dqne_pkg, dns_query_name_extractor and dns_query_name_extractor_chk

module dns_query_name_extractor_tb;
    import dqne_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int error_count;
    int results_due;
    int stall_cycles = 0;
    int bytes_in_phase;

    logic [7:0] frame_bytes[$];

    dns_query_name_extractor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dns_query_name_extractor_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .results_due (results_due)
    );

    always #5 aclk = ~aclk;

    // result side backpressure: ready runs broken by short and occasional long stalls
    initial begin
        int run_len;
        int stall_len;
        int pick;
        forever begin
            m_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(1, 40);
            repeat (run_len) @(negedge aclk);
            pick = $urandom_range(0, 99);
            if (pick < 50) stall_len = 0;
            else if (pick < 90) stall_len = $urandom_range(1, 3);
            else stall_len = $urandom_range(8, 30);
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
            end
        end
    end

    // ends a run in which no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("dns_query_name_extractor test failed");
                $finish;
            end
        end
    end

    task automatic push_random_bytes(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom));
    endtask

    // fills frame_bytes with one frame: mostly dns queries, some rejects, noise and cut frames
    task automatic build_frame(input logic [15:0] port);
        int          kind;
        int          ihl;
        int          words;
        int          n_labels;
        int          lbl_bytes;
        int          cut;
        logic [15:0] ethertype;
        logic [15:0] udp_dport;
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [3:0]  version;
        kind = $urandom_range(0, 99);
        frame_bytes.delete();
        if (kind >= 90) begin
            push_random_bytes($urandom_range(1, 40));
            return;
        end
        push_random_bytes(12);
        ethertype = ETHERTYPE_IPV4;
        if (kind >= 70 && kind < 75) begin
            ethertype = 16'($urandom);
            if ($urandom_range(0, 1)) ethertype[15:8] = 8'h08;
            if (ethertype == ETHERTYPE_IPV4) ethertype[0] = 1'b1;
        end
        frame_bytes.push_back(ethertype[15:8]);
        frame_bytes.push_back(ethertype[7:0]);
        ihl     = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
        words   = (ihl < 5) ? 5 : ihl;
        version = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
        frame_bytes.push_back({version, 4'(ihl)});
        push_random_bytes(8);
        proto = IP_PROTO_UDP;
        if (kind >= 75 && kind < 80) begin
            proto = 8'($urandom);
            if (proto == IP_PROTO_UDP) proto[0] = ~proto[0];
        end
        frame_bytes.push_back(proto);
        push_random_bytes(4 * words - 10);
        // udp header
        push_random_bytes(2);
        udp_dport = port;
        if (kind >= 80 && kind < 85) udp_dport = port ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(udp_dport[15:8]);
        frame_bytes.push_back(udp_dport[7:0]);
        push_random_bytes(4);
        // dns header, qr bit set only for the response case
        push_random_bytes(2);
        flags    = 8'($urandom);
        flags[7] = (kind >= 85 && kind < 90);
        frame_bytes.push_back(flags);
        push_random_bytes(9);
        n_labels = $urandom_range(0, 4);
        repeat (n_labels) begin
            lbl_bytes = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 70);
            frame_bytes.push_back(8'(lbl_bytes));
            push_random_bytes(lbl_bytes);
        end
        frame_bytes.push_back(8'd0);
        push_random_bytes($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
    endtask

    task automatic send_frame();
        bit no_gaps;
        int gap;
        int pick;
        no_gaps = ($urandom_range(0, 9) < 3);
        foreach (frame_bytes[i]) begin
            gap = 0;
            if (!no_gaps) begin
                pick = $urandom_range(0, 99);
                if (pick >= 92) gap = $urandom_range(6, 25);
                else if (pick >= 65) gap = $urandom_range(1, 3);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= {frame_bytes[i], i == frame_bytes.size() - 1};
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
        end
        bytes_in_phase += frame_bytes.size();
    endtask

    // registers change only once every name result is out and the pipeline drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    initial begin
        int          name_len;
        logic [15:0] port;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // one zero byte that is also the end of the frame
        frame_bytes = '{8'h00};
        send_frame();
        // not ipv4, then bytes ignored until an end that gives nothing
        frame_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'hff, 8'hff, 8'h00, 8'hff};
        send_frame();
        // short frame of all-ones bytes
        frame_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_frame();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin name_len = 256; port = 16'd53; end
                1: begin name_len = 1; port = 16'h0000; end
                2: begin name_len = 2; port = 16'hffff; end
                3: begin name_len = $urandom_range(3, 12); port = 16'($urandom); end
                4: begin name_len = 256; port = 16'($urandom); end
                default: begin name_len = $urandom_range(1, 256); port = 16'd53; end
            endcase
            wait_idle();
            write_reg(CFG_MAX_NAME_LEN, CFG_DATA_W'(name_len));
            write_reg(CFG_DNS_PORT, port);
            cfg_we <= 1'b0;
            bytes_in_phase = 0;
            while (bytes_in_phase < 30) begin
                build_frame(port);
                send_frame();
            end
        end

        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0 && results_due == 0) begin
            $display("dns_query_name_extractor test passed");
        end else begin
            $display("dns_query_name_extractor test failed");
        end
        $finish;
    end

endmodule
